>>> rtl/core/tfj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfj_pkg
// shared constants and controller/datapath types for the text justifier
// ----------------------------------------------------------------------------
package tfj_pkg;

	localparam int MAX_WIDTH = 32;
	localparam int MAX_WORDS = 16;
	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [5:0] WIDTH_RESET = 6'd16;

	typedef struct packed {
		logic take;
		logic copy;
		logic div;
		logic full;
		logic emit;
		logic line_clear;
	} tfj_cmd_t;

	typedef struct packed {
		logic tend;
		logic wl_zero;
		logic words_zero;
		logic need_break;
		logic copy_last;
		logic div_done;
		logic emit_done;
	} tfj_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/tfj_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfj_in_if
// request channel carrying text bytes and word / text end marks
// ----------------------------------------------------------------------------
interface tfj_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       byte_valid;
	logic       word_end;
	logic       text_end;

	modport source (output valid, text_byte, byte_valid, word_end, text_end, input ready);
	modport sink (input valid, text_byte, byte_valid, word_end, text_end, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tfj_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfj_out_if
// request channel carrying justified line bytes
// ----------------------------------------------------------------------------
interface tfj_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       line_last;
	logic       word_cut;

	modport source (output valid, out_byte, line_last, word_cut, input ready);
	modport sink (input valid, out_byte, line_last, word_cut, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tfj_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfj_dp
// word and line stores, gap divider, line walker and output register
// ----------------------------------------------------------------------------
module tfj_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfj_pkg::tfj_cmd_t cmd,
	output tfj_pkg::tfj_sts_t    sts,
	input  wire logic            cfg_we,
	input  wire logic [5:0]      cfg_wdata,
	input  wire logic [7:0]      text_byte,
	input  wire logic            byte_valid,
	input  wire logic            text_end,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 line_last,
	output logic                 word_cut
);
	import tfj_pkg::*;

	localparam logic [1:0] PH_LET = 2'd0;
	localparam logic [1:0] PH_GAP = 2'd1;
	localparam logic [1:0] PH_PAD = 2'd2;

	logic [7:0] word_mem [MAX_WIDTH];
	logic [7:0] line_mem [MAX_WIDTH];
	logic [4:0] gap_q    [MAX_WORDS];

	logic [5:0] width_q;
	logic [5:0] wl_q;
	logic [5:0] letters_q;
	logic [4:0] words_q;
	logic       cut_q;
	logic       tend_q;
	logic [4:0] j_q;
	logic [2:0] cnt_q;
	logic [5:0] dq_q;
	logic [3:0] dr_q;
	logic       full_q;
	logic [5:0] base_q;
	logic [3:0] rem_q;
	logic [5:0] pos_q;
	logic [3:0] k_q;
	logic [5:0] i_q;
	logic [5:0] sp_q;
	logic [1:0] ph_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;
	logic       oc_q;

	logic [5:0] w;
	logic [5:0] wlc;
	logic       cut;
	logic [6:0] fit_sum;
	logic [5:0] spare;
	logic [3:0] gaps;
	logic [4:0] tmp;
	logic       qbit;
	logic [4:0] kn;
	logic       has_next;
	logic [5:0] e;
	logic [5:0] g;
	logic       slot_free;
	logic       step;
	logic       load;
	logic [7:0] load_byte;
	logic [4:0] lidx;

	always_comb begin
		if (width_q == 6'd0) begin
			w = 6'd1;
		end else if (width_q > 6'(MAX_WIDTH)) begin
			w = 6'(MAX_WIDTH);
		end else begin
			w = width_q;
		end
	end

	assign wlc      = (wl_q < w) ? wl_q : w;
	assign cut      = wl_q > w;
	assign fit_sum  = {1'b0, letters_q} + {2'b00, words_q} + {1'b0, wlc};
	assign spare    = (w > letters_q) ? (w - letters_q) : 6'd0;
	assign gaps     = words_q[3:0] - 4'd1;
	assign tmp      = {dr_q, dq_q[5]};
	assign qbit     = tmp >= {1'b0, gaps};
	assign kn       = {1'b0, k_q} + 5'd1;
	assign has_next = kn < words_q;
	assign e        = has_next ? {1'b0, gap_q[kn[3:0]]} : letters_q;
	assign g        = base_q + ((k_q < rem_q) ? 6'd1 : 6'd0);
	assign lidx     = letters_q[4:0] + j_q;

	assign sts.tend       = tend_q;
	assign sts.wl_zero    = wl_q == 6'd0;
	assign sts.words_zero = words_q == 5'd0;
	assign sts.need_break = (words_q != 5'd0)
		&& ((fit_sum > {1'b0, w}) || (words_q >= 5'(MAX_WORDS)));
	assign sts.copy_last  = ({1'b0, j_q} + 6'd1) == wlc;
	assign sts.div_done   = cnt_q == 3'd7;
	assign sts.emit_done  = pos_q == w;

	assign slot_free = !ov_q || out_ready;
	assign step      = cmd.emit && (pos_q != w) && slot_free;

	always_comb begin
		load      = 1'b0;
		load_byte = SPACE_CHAR;
		case (ph_q)
			PH_LET: begin
				if (i_q < e) begin
					load      = step;
					load_byte = line_mem[i_q[4:0]];
				end
			end
			PH_GAP: load = step && (sp_q != 6'd0);
			PH_PAD: load = step;
			default: load = 1'b0;
		endcase
	end

	// configuration and line bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			wl_q      <= 6'd0;
			letters_q <= 6'd0;
			words_q   <= 5'd0;
			cut_q     <= 1'b0;
			tend_q    <= 1'b0;
			j_q       <= 5'd0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (cmd.take) begin
				tend_q <= text_end;
				if (byte_valid && wl_q < 6'(MAX_WIDTH + 1)) begin
					wl_q <= wl_q + 6'd1;
				end
			end
			if (cmd.copy) begin
				if (sts.copy_last) begin
					letters_q <= letters_q + wlc;
					words_q   <= words_q + 5'd1;
					cut_q     <= cut_q | cut;
					wl_q      <= 6'd0;
					j_q       <= 5'd0;
				end else begin
					j_q <= j_q + 5'd1;
				end
			end
			if (cmd.line_clear) begin
				letters_q <= 6'd0;
				words_q   <= 5'd0;
				cut_q     <= 1'b0;
			end
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (cmd.take && byte_valid && wl_q < 6'(MAX_WIDTH)) begin
			word_mem[wl_q[4:0]] <= text_byte;
		end
		if (cmd.copy) begin
			line_mem[lidx] <= word_mem[j_q];
			if (sts.copy_last) begin
				gap_q[words_q[3:0]] <= letters_q[4:0];
			end
		end
	end

	// gap divider and line walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			full_q <= 1'b0;
			ph_q   <= PH_LET;
			pos_q  <= 6'd0;
		end else begin
			if (!cmd.div) begin
				cnt_q <= 3'd0;
			end else if (cnt_q == 3'd0) begin
				dq_q   <= spare;
				dr_q   <= 4'd0;
				full_q <= cmd.full;
				cnt_q  <= 3'd1;
			end else if (cnt_q != 3'd7) begin
				dr_q  <= qbit ? 4'(tmp - {1'b0, gaps}) : tmp[3:0];
				dq_q  <= {dq_q[4:0], qbit};
				cnt_q <= cnt_q + 3'd1;
			end else begin
				if (full_q && gaps != 4'd0) begin
					base_q <= dq_q;
					rem_q  <= dr_q;
				end else begin
					base_q <= 6'd1;
					rem_q  <= 4'd0;
				end
				pos_q <= 6'd0;
				k_q   <= 4'd0;
				i_q   <= 6'd0;
				ph_q  <= PH_LET;
			end
			if (step) begin
				if (load) begin
					pos_q <= pos_q + 6'd1;
				end
				case (ph_q)
					PH_LET: begin
						if (i_q < e) begin
							i_q <= i_q + 6'd1;
						end else if (has_next) begin
							ph_q <= PH_GAP;
							sp_q <= g;
						end else begin
							ph_q <= PH_PAD;
						end
					end
					PH_GAP: begin
						if (sp_q != 6'd0) begin
							sp_q <= sp_q - 6'd1;
						end else begin
							k_q  <= kn[3:0];
							ph_q <= PH_LET;
						end
					end
					default: ph_q <= PH_PAD;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_q <= load_byte;
			ol_q <= (pos_q + 6'd1) == w;
			oc_q <= cut_q;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign line_last = ol_q;
	assign word_cut  = oc_q;

endmodule
`default_nettype wire

>>> rtl/core/tfj_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfj_ctrl
// sequencer for word intake, line break, word copy and line emission
// ----------------------------------------------------------------------------
module tfj_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_closes,
	output logic                   in_ready,
	input  wire tfj_pkg::tfj_sts_t sts,
	output tfj_pkg::tfj_cmd_t      cmd
);
	import tfj_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIN  = 3'd1;
	localparam logic [2:0] S_COPY = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       full_q;
	logic       full_d;
	logic       ret_q;
	logic       ret_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		full_d  = full_q;
		ret_d   = ret_q;
		cmd     = '0;
		cmd.full = full_q;
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && in_closes) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.wl_zero) begin
					if (sts.tend && !sts.words_zero) begin
						full_d  = 1'b0;
						ret_d   = 1'b0;
						state_d = S_DIV;
					end else begin
						state_d = S_IDLE;
					end
				end else if (sts.need_break) begin
					full_d  = 1'b1;
					ret_d   = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) begin
					if (sts.tend) begin
						full_d  = 1'b0;
						ret_d   = 1'b0;
						state_d = S_DIV;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_done) begin
					cmd.line_clear = 1'b1;
					state_d = ret_q ? S_COPY : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q  <= 1'b0;
			ret_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			full_q  <= full_d;
			ret_q   <= ret_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/text_full_justify_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_full_justify_top
// greedy fully justified line formatter for a byte stream of words
//
// text_in takes one request per item: a non-space byte (byte_valid), a
// word_end mark and a text_end mark. line_out gives one request per line
// byte; every line is exactly the effective width long, line_last marks its
// final byte and word_cut marks every byte of a line with a truncated word.
// cfg_we / cfg_wdata set the line width (reset value 16, 0 acts as 1,
// above 32 acts as 32); write it only while the block is idle.
// An item without a word or text end is taken directly in the idle state.
// Closing a word passes a finish state, then copies the word byte by byte
// into the line store. A line break or flush runs the gap divider, then the
// line walker emits the line bytes, with extra steps at each word and gap
// boundary. The line walker sets the throughput.
// Reset clears the word, line and controller state and sets the width to 16; no clearing pass.
// When line_out stalls, the walker holds and the one-entry output register
// keeps its byte; text_in is not ready from a word close until its copy
// and any line emission it causes are done.
// ----------------------------------------------------------------------------
module text_full_justify_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	tfj_in_if.sink          text_in,
	tfj_out_if.source       line_out
);
	import tfj_pkg::*;

	tfj_cmd_t cmd;
	tfj_sts_t sts;

	tfj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text_in.valid),
		.in_closes (text_in.word_end | text_in.text_end),
		.in_ready  (text_in.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tfj_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.text_byte  (text_in.text_byte),
		.byte_valid (text_in.byte_valid),
		.text_end   (text_in.text_end),
		.out_valid  (line_out.valid),
		.out_ready  (line_out.ready),
		.out_byte   (line_out.out_byte),
		.line_last  (line_out.line_last),
		.word_cut   (line_out.word_cut)
	);

endmodule
`default_nettype wire

>>> bench/tfj_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfj_tb_if
// note: the channel interfaces come with the rtl (tfj_in_if, tfj_out_if);
// this file only holds the shared bench-side request type
// ----------------------------------------------------------------------------
package tfj_tb_pkg;
	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       word_end;
		logic       text_end;
	} text_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       line_last;
		logic       word_cut;
	} line_req_t;
endpackage

>>> bench/text_full_justify_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_full_justify_checker
// watches both channels, forms the expected justified line bytes from each
// accepted text request and compares every accepted line byte in order
// ----------------------------------------------------------------------------
module text_full_justify_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_byte_valid,
	input  wire logic       in_word_end,
	input  wire logic       in_text_end,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       out_line_last,
	input  wire logic       out_word_cut,
	output int              fail_count,
	output int              pending_bytes
);
	import tfj_pkg::*;
	import tfj_tb_pkg::*;

	logic [7:0] line_buf [MAX_WIDTH];
	logic [4:0] word_starts [MAX_WORDS];
	logic [7:0] word_buf [MAX_WIDTH];
	int         word_len;
	int         letters;
	int         words;
	logic       cut_flag;
	logic [5:0] width_reg;
	line_req_t  expected_bytes [$];

	assign pending_bytes = expected_bytes.size();

	function automatic int line_width_eff();
		if (width_reg < 1) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit last);
		line_req_t r;
		r.out_byte = b;
		r.line_last = last;
		r.word_cut = cut_flag;
		expected_bytes.insert(expected_bytes.size(), r);
	endtask

	task automatic justify_line(input bit full);
		int w, gaps, spare, base, rem, pos, s, e, g;
		w = line_width_eff();
		gaps = words > 0 ? words - 1 : 0;
		spare = w > letters ? w - letters : 0;
		base = 1;
		rem = 0;
		pos = 0;
		if (words == 0) return;
		if (full && gaps > 0) begin
			base = spare / gaps;
			rem = spare % gaps;
		end
		for (int k = 0; k < words && k < MAX_WORDS; k++) begin
			s = word_starts[k];
			e = (k + 1 < words && k + 1 < MAX_WORDS) ? word_starts[k + 1] : letters;
			if (e > MAX_WIDTH) e = MAX_WIDTH;
			for (int i = s; i < e && pos < w; i++, pos++)
				push_byte(line_buf[i], pos + 1 == w);
			if (k + 1 < words) begin
				g = base + (k < rem ? 1 : 0);
				for (int i = 0; i < g && pos < w; i++, pos++)
					push_byte(SPACE_CHAR, pos + 1 == w);
			end
		end
		while (pos < w) begin
			push_byte(SPACE_CHAR, pos + 1 == w);
			pos++;
		end
		letters = 0;
		words = 0;
		cut_flag = 1'b0;
	endtask

	task automatic close_word();
		int w, wl;
		bit cut;
		w = line_width_eff();
		if (word_len == 0) return;
		wl = word_len < w ? word_len : w;
		cut = word_len > w;
		if (words > 0 && (letters + words + wl > w || words >= MAX_WORDS))
			justify_line(1'b1);
		if (letters + wl > MAX_WIDTH || words >= MAX_WORDS)
			justify_line(1'b1);
		word_starts[words] = letters[4:0];
		for (int i = 0; i < wl; i++)
			line_buf[letters + i] = word_buf[i];
		letters += wl;
		words++;
		cut_flag |= cut;
		word_len = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_req_t exp_r;
		if (!arst_n) begin
			word_len = 0;
			letters = 0;
			words = 0;
			cut_flag = 1'b0;
			width_reg = WIDTH_RESET;
			fail_count = 0;
			expected_bytes.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected line byte, actual %h/%b/%b", $time,
						out_byte, out_line_last, out_word_cut);
					fail_count++;
				end else begin
					exp_r = expected_bytes.pop_front();
					if (exp_r.out_byte !== out_byte || exp_r.line_last !== out_line_last
						|| exp_r.word_cut !== out_word_cut) begin
						$display("%0t: line byte mismatch, expected %h/%b/%b actual %h/%b/%b",
							$time, exp_r.out_byte, exp_r.line_last, exp_r.word_cut,
							out_byte, out_line_last, out_word_cut);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				width_reg = cfg_wdata;
			if (in_valid && in_ready) begin
				if (in_byte_valid) begin
					if (word_len < MAX_WIDTH) word_buf[word_len] = in_byte;
					if (word_len < MAX_WIDTH + 1) word_len++;
				end
				if (in_word_end || in_text_end) close_word();
				if (in_text_end) justify_line(1'b0);
			end
		end
	end

endmodule

>>> bench/text_full_justify_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_full_justify_top_tb
// drives words of random length and content through the justifier at
// several line widths, with random gaps and stalls on both channels, and
// lets the checker compare every line byte against its own prediction
// ----------------------------------------------------------------------------
module text_full_justify_top_tb;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [5:0] cfg_wdata;
	int         fail_count;
	int         pending_bytes;
	bit         hold_off;

	tfj_in_if  text_in ();
	tfj_out_if line_out ();

	text_full_justify_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.text_in  (text_in.sink),
		.line_out (line_out.source)
	);

	text_full_justify_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (text_in.valid),
		.in_ready     (text_in.ready),
		.in_byte      (text_in.text_byte),
		.in_byte_valid(text_in.byte_valid),
		.in_word_end  (text_in.word_end),
		.in_text_end  (text_in.text_end),
		.out_valid    (line_out.valid),
		.out_ready    (line_out.ready),
		.out_byte     (line_out.out_byte),
		.out_line_last(line_out.line_last),
		.out_word_cut (line_out.word_cut),
		.fail_count   (fail_count),
		.pending_bytes(pending_bytes)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	// line side: random wait per request, plus a long hold-off on request
	initial begin
		int n;
		line_out.ready = 0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if ($urandom_range(0, 1)) n = 0;
			if (n > 0 || hold_off) begin
				line_out.ready <= 0;
				repeat (n) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			line_out.ready <= 1;
			do @(posedge clk); while (!line_out.valid);
		end
	end

	task automatic send(input logic [7:0] b, input bit bv, input bit we, input bit te,
		input bit no_gap);
		int n;
		n = no_gap ? 0 : $urandom_range(0, 10);
		if (!no_gap && $urandom_range(0, 2) == 0) n = 0;
		if (n > 0) begin
			text_in.valid <= 0;
			repeat (n) @(posedge clk);
		end
		text_in.valid <= 1;
		text_in.text_byte <= b;
		text_in.byte_valid <= bv;
		text_in.word_end <= we;
		text_in.text_end <= te;
		do @(posedge clk); while (!text_in.ready);
	endtask

	task automatic send_word(input int len, input bit te, input bit no_gap);
		for (int i = 0; i < len; i++)
			send(8'($urandom_range(0, 255)), 1'b1, i == len - 1, te && i == len - 1, no_gap);
	endtask

	task automatic drain();
		text_in.valid <= 0;
		@(posedge clk);
		while (pending_bytes != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// waits until the block is idle and every line byte has left, then writes the width
	task automatic set_width(input logic [5:0] w);
		text_in.valid <= 0;
		@(posedge clk);
		while (!text_in.ready || pending_bytes != 0) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int len;
		logic [5:0] widths [8];
		widths = '{6'd16, 6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd33, 6'd12};
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		hold_off = 0;
		text_in.valid = 0;
		text_in.text_byte = 0;
		text_in.byte_valid = 0;
		text_in.word_end = 0;
		text_in.text_end = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, empty word, cut word, open word at text end
		send(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
		send(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
		send(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
		send(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
		send_word(20, 1'b0, 1'b0);
		send_word(3, 1'b0, 1'b0);
		send_word(5, 1'b0, 1'b0);
		send(8'h41, 1'b1, 1'b0, 1'b0, 1'b0);
		send(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
		send(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
		drain();
		set_width(6'd32);
		for (int i = 0; i < 17; i++) send_word(1, 1'b0, 1'b1);
		send(8'h5a, 1'b1, 1'b0, 1'b1, 1'b0);
		drain();

		// width change mid-line
		set_width(6'd20);
		send_word(8, 1'b0, 1'b0);
		send_word(8, 1'b0, 1'b0);
		set_width(6'd4);
		send(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
		drain();

		// fill-up with receiver held off
		set_width(6'd8);
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++) send_word($urandom_range(1, 6), 1'b0, 1'b1);
		join
		send(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_width(widths[p]);
			for (int i = 0; i < 10; i++) begin
				case ($urandom_range(0, 9))
					0: send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
					1: send_word($urandom_range(1, 3), 1'b1, 1'b0);
					default: begin
						len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 36)
							: $urandom_range(1, 6);
						send_word(len, 1'b0, ($urandom_range(0, 3) == 0));
					end
				endcase
			end
			send(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
			drain();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
